>>> sv/quoted_printable_encoder_unit_defines.svh
// Assertion helpers shared by the encoder modules.
`ifndef QUOTED_PRINTABLE_ENCODER_UNIT_DEFINES_SVH
`define QUOTED_PRINTABLE_ENCODER_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define QPE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define QPE_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

>>> sv/qpe_pkg.sv
package qpe_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [9:0] WRAP_LEN_RESET = 10'd76;

  typedef enum logic [1:0] {
    JOB_LIT,
    JOB_ESC,
    JOB_CRLF
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic        brk;
    logic [7:0]  data;
    logic        run_end;
    logic        msg_end;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    return (nib < 4'd10) ? (8'h30 + ext) : (8'h37 + ext);
  endfunction

endpackage

>>> sv/qpe_front.sv
`include "quoted_printable_encoder_unit_defines.svh"

module qpe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [9:0]    cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_final_i,
  input  logic          q_full_i,
  output logic          push_o,
  output qpe_pkg::job_t job_o
);
  import qpe_pkg::*;

  logic [9:0]  wrap_len_q, wrap_len_d;
  logic [7:0]  held_byte_q, held_byte_d;
  logic        held_valid_q, held_valid_d;
  logic [9:0]  col_q, col_d;
  logic        pend_q, pend_d;
  logic [7:0]  pend_byte_q, pend_byte_d;

  logic        acc, crlf, two_jobs;
  logic [7:0]  enc_byte;
  logic        enc_trail, enc_wsp, enc_print, enc_esc, enc_soft;
  logic [1:0]  enc_need;
  logic [11:0] enc_sum, enc_limit;
  logic [9:0]  enc_col_next;

  assign in_ready_o = !pend_q && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign crlf       = held_valid_q && (held_byte_q == CH_CR) && (in_byte_i == CH_LF);
  assign two_jobs   = held_valid_q && !crlf && in_final_i;

  always_comb begin
    if (pend_q) begin
      enc_byte  = pend_byte_q;
      enc_trail = 1'b1;
    end else if (held_valid_q) begin
      enc_byte  = held_byte_q;
      enc_trail = ((held_byte_q == CH_SP) || (held_byte_q == CH_TAB)) &&
                  ((in_byte_i == CH_CR) || (in_byte_i == CH_LF));
    end else begin
      enc_byte  = in_byte_i;
      enc_trail = 1'b1;
    end
    enc_wsp   = (enc_byte == CH_SP) || (enc_byte == CH_TAB);
    enc_print = (enc_byte >= CH_PRINT_LO) && (enc_byte <= CH_PRINT_HI) && (enc_byte != CH_EQ);
    enc_esc   = !enc_print && !(enc_wsp && !enc_trail);
    enc_need  = enc_esc ? 2'd3 : 2'd1;
    enc_sum   = {2'b00, col_q} + {10'd0, enc_need};
    enc_limit = {2'b00, wrap_len_q} - ((!enc_esc && enc_wsp) ? 12'd2 : 12'd1);
    enc_soft  = $signed(enc_sum) > $signed(enc_limit);
    enc_col_next = enc_soft ? {8'd0, enc_need} : enc_sum[9:0];
  end

  always_comb begin
    job_o.kind    = crlf && !pend_q ? JOB_CRLF : (enc_esc ? JOB_ESC : JOB_LIT);
    job_o.brk     = (crlf && !pend_q) ? 1'b0 : enc_soft;
    job_o.data    = enc_byte;
    job_o.run_end = pend_q ? 1'b1 : !two_jobs;
    job_o.msg_end = pend_q ? 1'b1 : (in_final_i && !two_jobs);
    push_o        = pend_q ? !q_full_i : (acc && (held_valid_q || in_final_i));
  end

  always_comb begin
    wrap_len_d   = cfg_valid_i ? cfg_data_i : wrap_len_q;
    held_byte_d  = held_byte_q;
    held_valid_d = held_valid_q;
    col_d        = col_q;
    pend_d       = pend_q;
    pend_byte_d  = pend_byte_q;
    if (pend_q && !q_full_i) begin
      pend_d = 1'b0;
      col_d  = '0;
    end else if (acc) begin
      held_valid_d = !crlf && !in_final_i;
      if (!crlf && !in_final_i) begin
        held_byte_d = in_byte_i;
      end
      pend_d      = two_jobs;
      pend_byte_d = in_byte_i;
      if (two_jobs) begin
        col_d = enc_col_next;
      end else if (in_final_i || crlf) begin
        col_d = '0;
      end else if (held_valid_q) begin
        col_d = enc_col_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_len_q   <= WRAP_LEN_RESET;
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      col_q        <= '0;
      pend_q       <= 1'b0;
    end else begin
      wrap_len_q   <= wrap_len_d;
      held_byte_q  <= held_byte_d;
      held_valid_q <= held_valid_d;
      col_q        <= col_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_byte_q <= pend_byte_d;
  end

  `QPE_ASSERT(a_pend_no_held, clk_i, rst_ni, pend_q |-> !held_valid_q, "Final byte pending while a byte is held.")
  `QPE_ASSERT(a_pend_after_final, clk_i, rst_ni, $rose(pend_q) |-> $past(in_final_i), "Pending job without a final beat.")

endmodule

>>> sv/qpe_fifo.sv
`include "quoted_printable_encoder_unit_defines.svh"

module qpe_fifo #(
  parameter int Depth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qpe_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output qpe_pkg::job_t head_o
);
  import qpe_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  job_t          mem_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  `QPE_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o && !pop_i, "Push into a full queue.")
  `QPE_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !valid_o, "Pop from an empty queue.")

endmodule

>>> sv/qpe_back.sv
`include "quoted_printable_encoder_unit_defines.svh"

module qpe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  qpe_pkg::job_t q_head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_char_o,
  output logic          out_run_end_o,
  output logic          out_msg_end_o
);
  import qpe_pkg::*;

  job_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [2:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       out_run_q, out_run_d;
  logic       out_msg_q, out_msg_d;

  logic       load, advance, last;
  logic [2:0] base, body_len, total, body_idx;
  logic [7:0] chr;

  always_comb begin
    base = cur_q.brk ? 3'd3 : 3'd0;
    case (cur_q.kind)
      JOB_LIT:  body_len = 3'd1;
      JOB_ESC:  body_len = 3'd3;
      JOB_CRLF: body_len = 3'd2;
      default:  body_len = 3'd1;
    endcase
    total    = base + body_len;
    last     = (idx_q == total - 3'd1);
    body_idx = idx_q - base;
    if (cur_q.brk && (idx_q < 3'd3)) begin
      case (idx_q)
        3'd0:    chr = CH_EQ;
        3'd1:    chr = CH_CR;
        default: chr = CH_LF;
      endcase
    end else begin
      case (cur_q.kind)
        JOB_ESC: begin
          case (body_idx)
            3'd0:    chr = CH_EQ;
            3'd1:    chr = hex_char(cur_q.data[7:4]);
            default: chr = hex_char(cur_q.data[3:0]);
          endcase
        end
        JOB_CRLF: chr = (body_idx == 3'd0) ? CH_CR : CH_LF;
        default:  chr = cur_q.data;
      endcase
    end
  end

  assign load    = !out_valid_q || out_ready_i;
  assign advance = cur_valid_q && load;
  assign pop_o   = q_valid_i && (!cur_valid_q || (advance && last));

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (advance) begin
      idx_d = idx_q + 3'd1;
      if (last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (pop_o) begin
      cur_d       = q_head_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_run_d   = out_run_q;
    out_msg_d   = out_msg_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_char_d  = chr;
      out_run_d   = cur_q.run_end && last;
      out_msg_d   = cur_q.msg_end && last;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
    out_run_q  <= out_run_d;
    out_msg_q  <= out_msg_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign out_run_end_o = out_run_q;
  assign out_msg_end_o = out_msg_q;

  `QPE_ASSERT(a_idx_range, clk_i, rst_ni, cur_valid_q |-> (idx_q < total), "Character index beyond its token.")
  `QPE_ASSERT(a_msg_has_run, clk_i, rst_ni, (out_valid_q && out_msg_q) |-> out_run_q, "Message end without run end.")

endmodule

>>> sv/quoted_printable_encoder_unit.sv
// Quoted-printable encoder, one message byte in and one encoded character out per beat.
// Throughput: one character per cycle while m_axis_tready is high and jobs are queued;
// a byte yields one to six characters, so an escaped byte occupies the output for three
// characters; a final beat after a held byte queues two jobs and holds the input until
// the second is queued.
// Reset clears the lookahead byte, column and queue, and sets the line length to 76.
module quoted_printable_encoder_unit #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tuser,   // [0] run_end
  output logic       m_axis_tlast
);
  import qpe_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  assign cfg_ready_o = 1'b1;

  qpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .job_o      (push_job)
  );

  qpe_fifo #(
    .Depth(FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_job_i(push_job),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .head_o    (head_job)
  );

  qpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head_job),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_char_o   (m_axis_tdata),
    .out_run_end_o(m_axis_tuser),
    .out_msg_end_o(m_axis_tlast)
  );

endmodule

>>> bench/qp_stream_checker.sv
`timescale 1ns / 100ps

module qp_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_o,
  input  logic [9:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,
  input  logic       m_axis_tuser,
  input  logic       m_axis_tlast,
  output int         fail_count_o,
  output int         pending_o
);
  import qpe_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_end;
    logic       msg_end;
  } qp_char_t;

  logic [9:0] wrap_len_q  = WRAP_LEN_RESET;
  logic [7:0] held_byte_q = '0;
  logic       held_q      = 1'b0;
  logic [9:0] column_q    = '0;

  qp_char_t   expected_chars[$];
  logic [7:0] step_chars[$];
  int         fail_count = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'd48 + 8'(n)) : (8'd55 + 8'(n));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Emits one token, preceded by a soft break when the line would overflow.
  task automatic encode_token(input logic [7:0] c, input logic trailing);
    logic blank;
    logic printable;
    logic escaped;
    int   width;
    int   limit;
    blank     = is_blank(c);
    printable = (c >= CH_PRINT_LO) && (c <= CH_PRINT_HI) && (c != CH_EQ);
    escaped   = !printable && !(blank && !trailing);
    width     = escaped ? 3 : 1;
    limit     = (!escaped && blank) ? int'(wrap_len_q) - 2 : int'(wrap_len_q) - 1;
    if (int'(column_q) + width > limit) begin
      step_chars.push_back(CH_EQ);
      step_chars.push_back(CH_CR);
      step_chars.push_back(CH_LF);
      column_q = '0;
    end
    if (escaped) begin
      step_chars.push_back(CH_EQ);
      step_chars.push_back(hex_digit(c[7:4]));
      step_chars.push_back(hex_digit(c[3:0]));
    end else begin
      step_chars.push_back(c);
    end
    column_q = column_q + 10'(width);
  endtask

  task automatic predict_beat(input logic [7:0] b, input logic fin);
    logic     consumed;
    qp_char_t item;
    int       last_idx;
    consumed = 1'b0;
    step_chars.delete();
    if (held_q) begin
      if (held_byte_q == CH_CR && b == CH_LF) begin
        step_chars.push_back(CH_CR);
        step_chars.push_back(CH_LF);
        column_q = '0;
        consumed = 1'b1;
      end else begin
        encode_token(held_byte_q, is_blank(held_byte_q) && (b == CH_CR || b == CH_LF));
      end
      held_q = 1'b0;
    end
    if (!consumed) begin
      if (fin) begin
        encode_token(b, 1'b1);
      end else begin
        held_byte_q = b;
        held_q      = 1'b1;
      end
    end
    if (fin) begin
      held_q   = 1'b0;
      column_q = '0;
    end
    last_idx = step_chars.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      item.ch      = step_chars[i];
      item.run_end = (i == last_idx);
      item.msg_end = fin && (i == last_idx);
      expected_chars.push_back(item);
    end
  endtask

  task automatic check_char();
    qp_char_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("unexpected character", m_axis_tdata, 0);
    end else begin
      want = expected_chars.pop_front();
      if (m_axis_tdata !== want.ch) begin
        report_mismatch("out_char", m_axis_tdata, want.ch);
      end
      if (m_axis_tuser !== want.run_end) begin
        report_mismatch("run_end", m_axis_tuser, want.run_end);
      end
      if (m_axis_tlast !== want.msg_end) begin
        report_mismatch("message_end", m_axis_tlast, want.msg_end);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_len_q  = WRAP_LEN_RESET;
      held_byte_q = '0;
      held_q      = 1'b0;
      column_q    = '0;
      expected_chars.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        wrap_len_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_char();
      end
    end
    pending_o    = expected_chars.size();
    fail_count_o = fail_count;
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import qpe_pkg::*;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [9:0] cfg_data_i    = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       s_axis_tlast  = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tuser;
  logic       m_axis_tlast;

  int         fail_count;
  int         pending;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         sent_beats  = 0;
  logic [7:0] msg_bytes[$];

  always #5 clk_i = ~clk_i;

  quoted_printable_encoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  qp_stream_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Each task below is entered at a falling edge and returns at one.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent_beats++;
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++) begin
      send_beat(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_wrap_len(input logic [9:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99, 0);
    if (r < 40) return 8'($urandom_range(8'h7E, 8'h21));
    if (r < 55) return ($urandom_range(1, 0) != 0) ? CH_SP : CH_TAB;
    if (r < 63) return CH_CR;
    if (r < 70) return CH_LF;
    if (r < 75) return CH_EQ;
    return 8'($urandom_range(255, 0));
  endfunction

  // Well-formed line breaks are mixed in so that blanks before them and
  // columns being cleared are exercised often.
  task automatic build_message(input int len);
    msg_bytes.delete();
    while (msg_bytes.size() < len) begin
      if ($urandom_range(9, 0) == 0) begin
        msg_bytes.push_back(CH_CR);
        msg_bytes.push_back(CH_LF);
      end else begin
        msg_bytes.push_back(pick_byte());
      end
    end
  endtask

  function automatic logic [9:0] wrap_len_for(input int phase);
    case (phase)
      0:       return 10'd5;
      1:       return 10'd1000;
      2:       return 10'd1023;
      3:       return 10'd0;
      4:       return 10'd1;
      5:       return 10'd2;
      6:       return 10'd3;
      7:       return 10'd4;
      8:       return 10'd12;
      9:       return 10'd76;
      10:      return 10'd30;
      default: return 10'($urandom_range(1000, 5));
    endcase
  endfunction

  initial begin
    int start;
    int len;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 6;
    rx_idle_pct = 88;

    msg_bytes = {8'h41};
    send_message();
    msg_bytes = {8'h00, 8'hFF, CH_EQ, CH_PRINT_LO, CH_PRINT_HI, CH_SP, CH_CR, CH_LF,
                 8'h78, CH_TAB, CH_LF, CH_SP, CH_CR, 8'h71, CH_CR, 8'h7A, CH_CR};
    send_message();
    msg_bytes = {8'h61, CH_SP};
    send_message();
    msg_bytes = {8'h62, CH_TAB};
    send_message();
    msg_bytes = {CH_CR, CH_LF};
    send_message();
    msg_bytes = {CH_LF};
    send_message();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase == 4) begin
        tx_idle_pct = 88;
        rx_idle_pct = 6;
      end else if (phase == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_idle();
      write_wrap_len(wrap_len_for(phase));
      start = sent_beats;
      while (sent_beats - start < 28) begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(120, 40) : $urandom_range(20, 1);
        if (len > 28 - (sent_beats - start)) begin
          len = 28 - (sent_beats - start);
        end
        build_message(len);
        send_message();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> quoted_printable_encoder_unit.f
+incdir+sv
sv/qpe_pkg.sv
sv/qpe_front.sv
sv/qpe_fifo.sv
sv/qpe_back.sv
sv/quoted_printable_encoder_unit.sv
bench/qp_stream_checker.sv
bench/tb.sv
